[rtl/mlos_pkg.sv]
// Package for the Markov log-odds site scorer: field widths, operation codes
// and the item and queue-entry types. Depends on nothing.
package mlos_pkg;

    localparam int MODEL_W     = 5;   // table set field
    localparam int ENTRY_POS_W = 7;   // position field of a table write
    localparam int BASE_W      = 2;   // one nucleotide, A=0 C=1 G=2 T=3
    localparam int VALUE_W     = 16;  // Q7.8 table entry as it arrives
    localparam int SCORE_W     = 32;  // sums and score, signed Q.8
    localparam int POS_W       = 8;   // window position index, holds up to 256 positions
    localparam int QUEUE_DEPTH = 4;   // entries between front and back

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_SCORE = 1'b1;

    typedef logic [1:0] op_kind_t;
    localparam op_kind_t OP_WRITE = 2'd0;  // store one table entry
    localparam op_kind_t OP_FIRST = 2'd1;  // first base of a window
    localparam op_kind_t OP_NEXT  = 2'd2;  // later base inside the window
    localparam op_kind_t OP_OVER  = 2'd3;  // base past the end of the table

    typedef struct packed {
        logic                      action;
        logic [MODEL_W-1:0]        model;
        logic [ENTRY_POS_W-1:0]    entry_position;
        logic [BASE_W-1:0]         entry_current_base;
        logic [BASE_W-1:0]         entry_previous_base;
        logic                      entry_negative;
        logic signed [VALUE_W-1:0] entry_value;
        logic [BASE_W-1:0]         base;
        logic                      last_base;
    } mlos_cmd_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [MODEL_W-1:0]        model_used;
        logic                      window_too_long;
    } mlos_result_t;

    // One classified item on its way from front to back.
    typedef struct packed {
        op_kind_t                  kind;
        logic                      neg;        // negative table, writes only
        logic [MODEL_W-1:0]        model;
        logic [POS_W-1:0]          position;
        logic [BASE_W-1:0]         cur;
        logic [BASE_W-1:0]         prev;
        logic signed [VALUE_W-1:0] value;
        logic                      zero_read;  // table set out of range: entries read as zero
        logic                      last;
        logic                      over;       // window has run past its end so far
    } mlos_op_t;

endpackage

[rtl/mlos_if.sv]
// Handshake channels of the site scorer: command items in, score items out.
// Depends on mlos_pkg.
interface mlos_cmd_if;
    import mlos_pkg::*;
    logic      valid;
    logic      ready;
    mlos_cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mlos_result_if;
    import mlos_pkg::*;
    logic         valid;
    logic         ready;
    mlos_result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/mlos_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mlos_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/mlos_queue.sv]
// Short FIFO of classified items between the front and the back.
// Depends on mlos_pkg.
module mlos_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mlos_pkg::mlos_op_t push_op,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output mlos_pkg::mlos_op_t head
);
    import mlos_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    mlos_op_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/mlos_front.sv]
// Front of the site scorer: takes command items, keeps the window position,
// previous base and table set, and hands classified items to the queue.
// Depends on mlos_pkg and mlos_if.
module mlos_front #(
    parameter int MODELS    = 32,
    parameter int POSITIONS = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    mlos_cmd_if.sink           cmd,
    input  logic               q_full,
    output logic               q_push,
    output mlos_pkg::mlos_op_t q_op
);
    import mlos_pkg::*;

    localparam int CW = $clog2(POSITIONS + 1);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [BASE_W-1:0]  prev_reg;
    logic [BASE_W-1:0]  prev_next;
    logic [MODEL_W-1:0] model_reg;
    logic [MODEL_W-1:0] model_next;
    logic               over_reg;
    logic               over_next;
    logic               accept;
    logic               keep;
    logic               write_ok;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && cmd.ready;
    assign write_ok  = (int'(cmd.data.model) < MODELS)
                    && (int'(cmd.data.entry_position) < POSITIONS);
    assign q_push    = accept && keep;

    always_comb
    begin
        q_op.kind      = OP_WRITE;
        q_op.neg       = cmd.data.entry_negative;
        q_op.model     = cmd.data.model;
        q_op.position  = POS_W'(cmd.data.entry_position);
        q_op.cur       = cmd.data.entry_current_base;
        q_op.prev      = cmd.data.entry_previous_base;
        q_op.value     = cmd.data.entry_value;
        q_op.zero_read = 1'b0;
        q_op.last      = 1'b0;
        q_op.over      = over_reg;
        keep           = 1'b0;
        count_next     = count_reg;
        prev_next      = prev_reg;
        model_next     = model_reg;
        over_next      = over_reg;

        if (cmd.data.action == ACT_WRITE)
        begin
            // drop writes outside the table
            keep = write_ok;
        end
        else
        begin
            keep      = 1'b1;
            q_op.last = cmd.data.last_base;
            if (count_reg == '0)
            begin
                q_op.kind     = OP_FIRST;
                q_op.model    = cmd.data.model;
                q_op.position = '0;
                q_op.cur      = '0;
                q_op.prev     = cmd.data.base;
                model_next    = cmd.data.model;
                prev_next     = cmd.data.base;
                count_next    = CW'(1);
            end
            else if (count_reg < CW'(POSITIONS))
            begin
                q_op.kind     = OP_NEXT;
                q_op.model    = model_reg;
                q_op.position = POS_W'(count_reg);
                q_op.cur      = cmd.data.base;
                q_op.prev     = prev_reg;
                prev_next     = cmd.data.base;
                count_next    = count_reg + CW'(1);
            end
            else
            begin
                q_op.kind  = OP_OVER;
                q_op.model = model_reg;
                q_op.over  = 1'b1;
                over_next  = 1'b1;
            end
            q_op.zero_read = !(int'(q_op.model) < MODELS);
            if (cmd.data.last_base)
            begin
                count_next = '0;
                prev_next  = '0;
                model_next = '0;
                over_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            prev_reg  <= '0;
            model_reg <= '0;
            over_reg  <= 1'b0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            prev_reg  <= prev_next;
            model_reg <= model_next;
            over_reg  <= over_next;
        end
    end

endmodule

[rtl/mlos_back.sv]
// Back of the site scorer: table memories, accumulation of the positive and
// negative sums, and the result register. Depends on mlos_pkg, mlos_if, mlos_ram.
module mlos_back #(
    parameter int MODELS     = 32,
    parameter int POSITIONS  = 128,
    parameter int ENTRY_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  mlos_pkg::mlos_op_t q_head,
    output logic               q_pop,
    mlos_result_if.source      result
);
    import mlos_pkg::*;

    localparam int ROW_W     = $clog2(MODELS * POSITIONS);
    localparam int ADDR_W    = ROW_W + 2 * BASE_W;
    localparam int TBL_DEPTH = MODELS * POSITIONS * 16;

    function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [SCORE_W:0] v);
        if (v[SCORE_W] != v[SCORE_W-1])
        begin
            sat_score = v[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
        end
        else
        begin
            sat_score = v[SCORE_W-1:0];
        end
    endfunction

    logic                       is_write;
    logic                       b_ready;
    logic                       rd_en;
    logic [ROW_W-1:0]           row;
    logic [ADDR_W-1:0]          addr;
    logic signed [SCORE_W-1:0]  value_ext;
    logic [ENTRY_BITS-1:0]      wdata;
    logic                       we_pos;
    logic                       we_neg;
    logic [ENTRY_BITS-1:0]      rd_pos;
    logic [ENTRY_BITS-1:0]      rd_neg;

    logic                       b_valid_reg;
    mlos_op_t                   b_op_reg;
    logic                       b_use;
    logic                       b_fire;
    logic signed [SCORE_W:0]    ent_pos;
    logic signed [SCORE_W:0]    ent_neg;
    logic signed [SCORE_W-1:0]  pos_sum_reg;
    logic signed [SCORE_W-1:0]  neg_sum_reg;
    logic signed [SCORE_W-1:0]  pos_sum_next;
    logic signed [SCORE_W-1:0]  neg_sum_next;

    logic                       c_valid_reg;
    logic                       c_ready;
    logic                       c_fire;
    logic signed [SCORE_W-1:0]  c_pos_reg;
    logic signed [SCORE_W-1:0]  c_neg_reg;
    logic [MODEL_W-1:0]         c_model_reg;
    logic                       c_over_reg;

    logic                       out_valid_reg;
    mlos_result_t               out_data_reg;

    // Issue: writes go straight to the memory, scoring bases need stage B free.
    assign is_write  = (q_head.kind == OP_WRITE);
    assign b_ready   = !b_valid_reg || b_fire;
    assign q_pop     = q_valid && (is_write || b_ready);
    assign rd_en     = q_pop && !q_head.zero_read
                    && ((q_head.kind == OP_FIRST) || (q_head.kind == OP_NEXT));
    assign row       = ROW_W'(q_head.model) * ROW_W'(POSITIONS) + ROW_W'(q_head.position);
    assign addr      = {row, q_head.cur, q_head.prev};
    assign value_ext = SCORE_W'(q_head.value);
    assign wdata     = value_ext[ENTRY_BITS-1:0];
    assign we_pos    = q_pop && is_write && !q_head.neg;
    assign we_neg    = q_pop && is_write && q_head.neg;

    mlos_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TBL_DEPTH)
    ) u_pos_table (
        .clk   (clk),
        .we    (we_pos),
        .waddr (addr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (addr),
        .rdata (rd_pos)
    );

    mlos_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TBL_DEPTH)
    ) u_neg_table (
        .clk   (clk),
        .we    (we_neg),
        .waddr (addr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (addr),
        .rdata (rd_neg)
    );

    // Stage B: read data is held by the memory while B stalls.
    assign b_use   = !b_op_reg.zero_read
                  && ((b_op_reg.kind == OP_FIRST) || (b_op_reg.kind == OP_NEXT));
    assign ent_pos = b_use ? (SCORE_W + 1)'(signed'(rd_pos)) : '0;
    assign ent_neg = b_use ? (SCORE_W + 1)'(signed'(rd_neg)) : '0;
    assign c_ready = !c_valid_reg || c_fire;
    assign b_fire  = b_valid_reg && (!b_op_reg.last || c_ready);

    always_comb
    begin
        unique case (b_op_reg.kind)
            OP_FIRST:
            begin
                pos_sum_next = ent_pos[SCORE_W-1:0];
                neg_sum_next = ent_neg[SCORE_W-1:0];
            end
            OP_NEXT:
            begin
                pos_sum_next = sat_score((SCORE_W + 1)'(pos_sum_reg) + ent_pos);
                neg_sum_next = sat_score((SCORE_W + 1)'(neg_sum_reg) + ent_neg);
            end
            default:
            begin
                pos_sum_next = pos_sum_reg;
                neg_sum_next = neg_sum_reg;
            end
        endcase
    end

    // Stage C and output register.
    assign c_fire       = c_valid_reg && (!out_valid_reg || result.ready);
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop && !is_write)
        begin
            b_op_reg <= q_head;
        end
        if (b_fire && b_op_reg.last)
        begin
            c_pos_reg   <= pos_sum_next;
            c_neg_reg   <= neg_sum_next;
            c_model_reg <= b_op_reg.model;
            c_over_reg  <= b_op_reg.over;
        end
        if (c_fire)
        begin
            out_data_reg.score <= sat_score((SCORE_W + 1)'(c_pos_reg)
                                          - (SCORE_W + 1)'(c_neg_reg));
            out_data_reg.model_used      <= c_model_reg;
            out_data_reg.window_too_long <= c_over_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            pos_sum_reg   <= '0;
            neg_sum_reg   <= '0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop && !is_write)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end

            if (b_fire)
            begin
                if (b_op_reg.last)
                begin
                    pos_sum_reg <= '0;
                    neg_sum_reg <= '0;
                end
                else
                begin
                    pos_sum_reg <= pos_sum_next;
                    neg_sum_reg <= neg_sum_next;
                end
            end

            if (b_fire && b_op_reg.last)
            begin
                c_valid_reg <= 1'b1;
            end
            else if (c_fire)
            begin
                c_valid_reg <= 1'b0;
            end

            if (c_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/markov_log_odds_site_scorer_unit.sv]
// After its last base is taken, a window's score passes the queue, stages B and C
// and the output register. Throughput: one item per cycle, table writes and bases
// alike, unless results stall; the pair of single-port-read table memories is
// read at most once per base. Reset clears window state, sums, queue and result
// stages at once; the tables are not cleared and hold no meaning until written.
module markov_log_odds_site_scorer_unit #(
    parameter int MODELS     = 32,
    parameter int POSITIONS  = 128,
    parameter int ENTRY_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    mlos_cmd_if.sink      cmd,
    mlos_result_if.source result
);
    import mlos_pkg::*;

    // Front to back queue signals.
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;
    mlos_op_t q_op;
    mlos_op_t q_head;

    // Front: accept command items, track window position, previous base and
    // the latched table set, and classify each item as a table write, the
    // first base, a later base or a base past the end of the table. Out-of-range
    // writes are dropped here; ready falls only when the queue is full.
    mlos_front #(
        .MODELS    (MODELS),
        .POSITIONS (POSITIONS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_full (q_full),
        .q_push (q_push),
        .q_op   (q_op)
    );

    // Queue: a few items of slack so that a stalled result channel does not
    // stop the front at once, and the front never waits on the memories.
    mlos_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_op),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .head    (q_head)
    );

    // Back: writes and reads of the positive and negative tables happen in
    // item order at the queue head, so a base always sees every earlier write.
    // Stage B adds the entries with saturation, stage C forms the difference,
    // and the output register holds the result until it is taken.
    mlos_back #(
        .MODELS     (MODELS),
        .POSITIONS  (POSITIONS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule
